/* hw/rtl/ttlq_pkg.sv */
// shared types, sizes and codes of the ttl ordered packet queue
package ttlq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int KEY_W       = 8;
	localparam int HANDLE_W    = 16;
	localparam int DIR_W       = 8;
	localparam int OCC_W       = 5;

	typedef enum logic [1:0] {
		ACT_ENQ   = 2'd0,
		ACT_DEQ   = 2'd1,
		ACT_PEEK  = 2'd2,
		ACT_FLUSH = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENQ_CMP,
		ST_ENQ_INS,
		ST_HEAD,
		ST_SHIFT,
		ST_RESULT
	} ttlq_state_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
		logic [DIR_W-1:0]    dir;
	} entry_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} ram_req_t;

	typedef struct packed {
		logic             ok;
		entry_t           head;
		logic [OCC_W-1:0] occ;
	} result_t;

endpackage

/* hw/rtl/ttlq_ram.sv */
// entry memory: one write port, one read port with registered read data
module ttlq_ram import ttlq_pkg::*; (
	input  logic     clk,
	input  ram_req_t req,
	output entry_t   rd_data
);

	entry_t mem [QUEUE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

/* hw/rtl/ttlq_ctrl.sv */
// sequencer: search and shift of the sorted entries through the single compare unit
module ttlq_ctrl import ttlq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [KEY_W-1:0]    ttl_key,
	input  logic [HANDLE_W-1:0] packet_handle,
	input  logic [DIR_W-1:0]    direction_in,
	output logic                res_valid,
	input  logic                res_ready,
	output result_t             res,
	output ram_req_t            ram_req,
	input  entry_t              rd_data
);

	ttlq_state_t        state_q, state_d;
	logic [COUNT_W-1:0] count_q;
	logic [ADDR_W-1:0]  idx_q;
	action_t            act_q;
	entry_t             new_q;
	logic               res_ok_q;
	entry_t             res_head_q;

	action_t            act_in;
	logic               full;
	logic               empty;
	logic               key_gt;
	logic               idx_zero;
	logic               idx_last;
	logic [COUNT_W-1:0] count_m1;

	assign act_in   = action_t'(action);
	assign full     = (count_q == COUNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign count_m1 = count_q - COUNT_W'(1);
	// shared compare: stored key strictly larger than the new key moves up
	assign key_gt   = (rd_data.key > new_q.key);
	assign idx_zero = (idx_q == '0);
	assign idx_last = (COUNT_W'(idx_q) == count_m1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (act_in)
						ACT_ENQ: begin
							if (full) begin
								state_d = ST_RESULT;
							end else if (empty) begin
								state_d = ST_ENQ_INS;
							end else begin
								state_d = ST_ENQ_CMP;
							end
						end
						ACT_DEQ, ACT_PEEK: begin
							state_d = empty ? ST_RESULT : ST_HEAD;
						end
						ACT_FLUSH: begin
							state_d = ST_RESULT;
						end
						default: state_d = ST_RESULT;
					endcase
				end
			end
			ST_ENQ_CMP: begin
				if (key_gt) begin
					state_d = idx_zero ? ST_ENQ_INS : ST_ENQ_CMP;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_ENQ_INS: begin
				state_d = ST_RESULT;
			end
			ST_HEAD: begin
				if (act_q == ACT_PEEK || count_q == COUNT_W'(1)) begin
					state_d = ST_RESULT;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				state_d = idx_last ? ST_RESULT : ST_SHIFT;
			end
			ST_RESULT: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory requests and handshake outputs
	always_comb begin
		ram_req  = '0;
		in_ready = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				ram_req.rd_en  = in_valid;
				ram_req.rd_addr = (act_in == ACT_ENQ) ? ADDR_W'(count_m1) : '0;
			end
			ST_ENQ_CMP: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = idx_q + ADDR_W'(1);
				if (key_gt) begin
					ram_req.wr_data = rd_data;
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = idx_q - ADDR_W'(1);
				end else begin
					ram_req.wr_data = new_q;
				end
			end
			ST_ENQ_INS: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = '0;
				ram_req.wr_data = new_q;
			end
			ST_HEAD: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = ADDR_W'(1);
			end
			ST_SHIFT: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = idx_q - ADDR_W'(1);
				ram_req.wr_data = rd_data;
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = idx_q + ADDR_W'(1);
			end
			ST_RESULT: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign res.ok   = res_ok_q;
	assign res.head = res_head_q;
	assign res.occ  = OCC_W'(count_q);

	// state register and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && act_in == ACT_FLUSH) begin
						count_q <= '0;
					end
				end
				ST_ENQ_CMP: begin
					if (!key_gt) begin
						count_q <= count_q + COUNT_W'(1);
					end
				end
				ST_ENQ_INS: begin
					count_q <= count_q + COUNT_W'(1);
				end
				ST_HEAD: begin
					if (act_q == ACT_DEQ && count_q == COUNT_W'(1)) begin
						count_q <= '0;
					end
				end
				ST_SHIFT: begin
					if (idx_last) begin
						count_q <= count_m1;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// transaction fields, scan index and pending result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					act_q      <= act_in;
					new_q      <= '{key: ttl_key, handle: packet_handle, dir: direction_in};
					idx_q      <= ADDR_W'(count_m1);
					res_head_q <= '0;
					unique case (act_in)
						ACT_ENQ:           res_ok_q <= !full;
						ACT_DEQ, ACT_PEEK: res_ok_q <= !empty;
						ACT_FLUSH:         res_ok_q <= 1'b1;
						default:           res_ok_q <= 1'b1;
					endcase
				end
			end
			ST_ENQ_CMP: begin
				if (key_gt) begin
					idx_q <= idx_q - ADDR_W'(1);
				end
			end
			ST_HEAD: begin
				res_head_q <= rd_data;
				idx_q      <= ADDR_W'(1);
			end
			ST_SHIFT: begin
				if (!idx_last) begin
					idx_q <= idx_q + ADDR_W'(1);
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

endmodule

/* hw/rtl/ttl_ordered_packet_queue_unit.sv */
// top level of the ttl ordered packet queue with its output register
//
// Earliest-deadline-first packet queue of QUEUE_DEPTH entries kept sorted by
// TTL, smallest first; an entry with a key equal to existing ones goes behind
// them. Each input transaction carries an action (enqueue, dequeue, peek,
// flush) and returns exactly one result transaction. The entries live in a
// single-port-write, single-port-read memory and one entry is moved per clock,
// so the queue works on one transaction at a time: an enqueue compares and
// moves up the entries with a larger TTL and then writes the new entry, a
// dequeue reads the head and shifts any remaining entries down, a peek reads
// the head, and a flush or a refused action goes straight to the result; the
// sequencer then returns to idle once the result is taken.
// The result sits in an output register, so a new transaction may be
// accepted while the previous result still waits to be taken.
module ttl_ordered_packet_queue_unit import ttlq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [KEY_W-1:0]    ttl_key,
	input  logic [HANDLE_W-1:0] packet_handle,
	input  logic [DIR_W-1:0]    direction_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                ok,
	output logic [HANDLE_W-1:0] head_handle,
	output logic [KEY_W-1:0]    head_ttl,
	output logic [DIR_W-1:0]    head_direction,
	output logic [OCC_W-1:0]    occupancy
);

	ram_req_t ram_req;
	entry_t   rd_data;
	result_t  res;
	logic     res_valid;
	logic     res_ready;
	logic     out_valid_q;
	result_t  out_q;

	ttlq_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	ttlq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.ttl_key       (ttl_key),
		.packet_handle (packet_handle),
		.direction_in  (direction_in),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.ram_req       (ram_req),
		.rd_data       (rd_data)
	);

	// output register takes a result when empty or being drained
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = out_q.ok;
	assign head_handle    = out_q.head.handle;
	assign head_ttl       = out_q.head.key;
	assign head_direction = out_q.head.dir;
	assign occupancy      = out_q.occ;

endmodule

/* verif/tb_ttl_ordered_packet_queue_unit.sv */
// testbench of the ttl ordered packet queue unit: directed table, random traffic, queue predictor
module tb_ttl_ordered_packet_queue_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ttlq_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_OPS  = 420;
	localparam int HOLD_CYCLES = 300;

	// one row of the directed table; typed rows carry their own expected result
	typedef struct packed {
		action_t             act;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
		logic [DIR_W-1:0]    dir;
		logic [4:0]          reps;
		logic                rnd;
		logic                typed;
		result_t             want;
	} op_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          action;
	logic [KEY_W-1:0]    ttl_key;
	logic [HANDLE_W-1:0] packet_handle;
	logic [DIR_W-1:0]    direction_in;
	logic                out_valid;
	logic                out_ready;
	logic                ok;
	logic [HANDLE_W-1:0] head_handle;
	logic [KEY_W-1:0]    head_ttl;
	logic [DIR_W-1:0]    head_direction;
	logic [OCC_W-1:0]    occupancy;

	// predictor state: entries sorted by ttl, head at index 0
	entry_t  held_entries[$];
	result_t pending_results[$];
	int      n_errors    = 0;
	int      n_accepted  = 0;
	int      burst_left  = 0;
	int      cycle_count = 0;

	ttl_ordered_packet_queue_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.ttl_key       (ttl_key),
		.packet_handle (packet_handle),
		.direction_in  (direction_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ok            (ok),
		.head_handle   (head_handle),
		.head_ttl      (head_ttl),
		.head_direction(head_direction),
		.occupancy     (occupancy)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// earliest-deadline-first queue: apply one operation, return its result
	function automatic result_t queue_apply(action_t act, logic [KEY_W-1:0] key,
			logic [HANDLE_W-1:0] handle, logic [DIR_W-1:0] dir);
		result_t res;
		entry_t  fresh;
		int      pos;
		res = '0;
		case (act)
			ACT_ENQ: begin
				if (held_entries.size() < QUEUE_DEPTH) begin
					// new entry goes behind every key that is equal or smaller
					pos = 0;
					while (pos < held_entries.size() && held_entries[pos].key <= key)
						pos++;
					fresh.key    = key;
					fresh.handle = handle;
					fresh.dir    = dir;
					held_entries.insert(pos, fresh);
					res.ok = 1'b1;
				end
			end
			ACT_DEQ: begin
				if (held_entries.size() != 0) begin
					res.ok   = 1'b1;
					res.head = held_entries[0];
					held_entries.delete(0);
				end
			end
			ACT_PEEK: begin
				if (held_entries.size() != 0) begin
					res.ok   = 1'b1;
					res.head = held_entries[0];
				end
			end
			default: begin
				held_entries.delete();
				res.ok = 1'b1;
			end
		endcase
		res.occ = OCC_W'(held_entries.size());
		return res;
	endfunction

	function automatic void check_field(string field, logic [15:0] want_v, logic [15:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
			n_errors++;
		end
	endfunction

	// offer one transaction, with bursts and gaps on the sending side
	task automatic send_op(action_t act, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] handle,
			logic [DIR_W-1:0] dir, logic typed, result_t want);
		result_t predicted;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8))
				@(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 12);
		end
		in_valid      <= 1'b1;
		action        <= act;
		ttl_key       <= key;
		packet_handle <= handle;
		direction_in  <= dir;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = queue_apply(act, key, handle, dir);
		pending_results.push_back(typed ? want : predicted);
		n_accepted++;
		burst_left--;
	endtask

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no transaction pending, expected none, actual ok %0b occ %0d",
					$time, ok, occupancy);
				n_errors++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				check_field("ok", 16'(want.ok), 16'(ok));
				check_field("head_handle", want.head.handle, head_handle);
				check_field("head_ttl", 16'(want.head.key), 16'(head_ttl));
				check_field("head_direction", 16'(want.head.dir), 16'(head_direction));
				check_field("occupancy", 16'(want.occ), 16'(occupancy));
			end
		end
	end

	// receiver: stall patterns that change over time, plus two long hold-offs
	initial begin
		int       mode;
		int       mode_left;
		int       holds_done;
		bit [7:0] pattern;
		mode       = 0;
		mode_left  = 0;
		holds_done = 0;
		pattern    = 8'hff;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holds_done < 2 && n_accepted >= 120 + 200 * holds_done) begin
				// hold off long enough that the queue backs up into its input
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
					pattern   = 8'($urandom_range(1, 255));
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: begin
						out_ready <= pattern[0];
						pattern = {pattern[0], pattern[7:1]};
					end
				endcase
			end
		end
	end

	// stimulus
	initial begin
		op_row_t             op_rows[0:16];
		action_t             act;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
		logic [DIR_W-1:0]    dir;
		int                  episode;
		int                  pick;
		int                  sent;

		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		action        <= ACT_ENQ;
		ttl_key       <= '0;
		packet_handle <= '0;
		direction_in  <= '0;

		// directed table: empty refusals, extremes, equal keys, fill to full
		op_rows = '{
			'{ACT_DEQ,   8'h00, 16'h0000, 8'h00, 5'd1, 1'b0, 1'b1,
				'{1'b0, '{8'h00, 16'h0000, 8'h00}, 5'd0}},
			'{ACT_PEEK,  8'h00, 16'h0000, 8'h00, 5'd1, 1'b0, 1'b1,
				'{1'b0, '{8'h00, 16'h0000, 8'h00}, 5'd0}},
			'{ACT_FLUSH, 8'h00, 16'h0000, 8'h00, 5'd1, 1'b0, 1'b1,
				'{1'b1, '{8'h00, 16'h0000, 8'h00}, 5'd0}},
			'{ACT_ENQ,   8'hff, 16'hffff, 8'hff, 5'd1, 1'b0, 1'b1,
				'{1'b1, '{8'h00, 16'h0000, 8'h00}, 5'd1}},
			'{ACT_ENQ,   8'h00, 16'h0000, 8'h00, 5'd1, 1'b0, 1'b1,
				'{1'b1, '{8'h00, 16'h0000, 8'h00}, 5'd2}},
			'{ACT_PEEK,  8'h00, 16'h0000, 8'h00, 5'd1, 1'b0, 1'b1,
				'{1'b1, '{8'h00, 16'h0000, 8'h00}, 5'd2}},
			'{ACT_ENQ,   8'h00, 16'ha5a5, 8'h5a, 5'd1, 1'b0, 1'b0, '0},
			'{ACT_ENQ,   8'h80, 16'h5a5a, 8'ha5, 5'd1, 1'b0, 1'b0, '0},
			'{ACT_DEQ,   8'h00, 16'h0000, 8'h00, 5'd1, 1'b0, 1'b1,
				'{1'b1, '{8'h00, 16'h0000, 8'h00}, 5'd3}},
			'{ACT_DEQ,   8'h00, 16'h0000, 8'h00, 5'd2, 1'b0, 1'b0, '0},
			'{ACT_DEQ,   8'h00, 16'h0000, 8'h00, 5'd1, 1'b0, 1'b1,
				'{1'b1, '{8'hff, 16'hffff, 8'hff}, 5'd0}},
			'{ACT_DEQ,   8'h00, 16'h0000, 8'h00, 5'd1, 1'b0, 1'b1,
				'{1'b0, '{8'h00, 16'h0000, 8'h00}, 5'd0}},
			'{ACT_ENQ,   8'h00, 16'h0000, 8'h00, 5'd16, 1'b1, 1'b0, '0},
			'{ACT_ENQ,   8'hff, 16'hffff, 8'hff, 5'd1, 1'b0, 1'b1,
				'{1'b0, '{8'h00, 16'h0000, 8'h00}, 5'd16}},
			'{ACT_PEEK,  8'h00, 16'h0000, 8'h00, 5'd1, 1'b0, 1'b0, '0},
			'{ACT_FLUSH, 8'h00, 16'h0000, 8'h00, 5'd1, 1'b0, 1'b1,
				'{1'b1, '{8'h00, 16'h0000, 8'h00}, 5'd0}},
			'{ACT_PEEK,  8'h00, 16'h0000, 8'h00, 5'd1, 1'b0, 1'b1,
				'{1'b0, '{8'h00, 16'h0000, 8'h00}, 5'd0}}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (op_rows[r]) begin
			for (int n = 0; n < op_rows[r].reps; n++) begin
				key    = op_rows[r].rnd ? KEY_W'($urandom) : op_rows[r].key;
				handle = op_rows[r].rnd ? HANDLE_W'($urandom) : op_rows[r].handle;
				dir    = op_rows[r].rnd ? DIR_W'($urandom) : op_rows[r].dir;
				send_op(op_rows[r].act, key, handle, dir, op_rows[r].typed, op_rows[r].want);
			end
		end

		// random episodes that lean toward filling, draining, mixing or equal keys
		sent = 0;
		while (sent < RANDOM_OPS) begin
			episode = $urandom_range(0, 3);
			repeat ($urandom_range(5, 40)) begin
				pick = $urandom_range(0, 99);
				case (episode)
					0:       act = (pick < 75) ? ACT_ENQ : (pick < 88) ? ACT_DEQ : ACT_PEEK;
					1:       act = (pick < 20) ? ACT_ENQ : (pick < 80) ? ACT_DEQ : ACT_PEEK;
					default: act = (pick < 50) ? ACT_ENQ : (pick < 82) ? ACT_DEQ : ACT_PEEK;
				endcase
				if ($urandom_range(0, 49) == 0)
					act = ACT_FLUSH;
				// equal keys are common in the tie episode and now and then elsewhere
				case ($urandom_range(0, 9))
					0:       key = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
					1, 2:    key = KEY_W'($urandom_range(0, 3));
					default: key = (episode == 3) ? KEY_W'($urandom_range(0, 3)) : KEY_W'($urandom);
				endcase
				handle = HANDLE_W'($urandom);
				dir    = DIR_W'($urandom);
				send_op(act, key, handle, dir, 1'b0, '0);
				sent++;
			end
		end
		in_valid <= 1'b0;

		// drain, then allow for the block's latency
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
